// File: rtl/ccr_pkg.sv
// Shared types, widths and helpers for the circle collision response pipeline.
package ccr_pkg;

  localparam int FRAC_BITS_DEF = 8;   // default fraction bits of positions and momenta
  localparam int NORM_EXTRA    = 8;   // extra fraction bits carried by the unit normal
  localparam int SQ_STEPS      = 21;  // one root bit per stage
  localparam int D2W           = 2 * SQ_STEPS; // squared distance bits that matter on a hit
  localparam int DISTW         = SQ_STEPS;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic        [19:0] r;
    logic signed [23:0] mx;
    logic signed [23:0] my;
  } circle_t;

  typedef struct packed {
    circle_t a;
    circle_t b;
    logic    swap;
  } pair_t;

  typedef struct packed {
    logic               collided;
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic signed [23:0] x2;
    logic signed [23:0] y2;
    logic signed [23:0] mx1;
    logic signed [23:0] my1;
    logic signed [23:0] mx2;
    logic signed [23:0] my2;
  } result_t;

  typedef struct packed {
    pair_t              p;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic        [20:0] rs;
    logic        [21:0] adx;
    logic        [21:0] ady;
    logic               hit;
  } geom_t;

  typedef struct packed {
    geom_t            g;
    logic [DISTW-1:0] dmag;
  } root_t;

  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    logic signed [23:0] r;
    if (v > 40'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -40'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/ccr_front.sv
// Front stages: center deltas, squares and the exact overlap test.
module ccr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ccr_pkg::pair_t                   in_pair,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ccr_pkg::geom_t                   geom,
  output logic [ccr_pkg::D2W-1:0]          d2
);

  localparam int S = 3;

  typedef struct packed {
    ccr_pkg::pair_t     p;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic        [20:0] rs;
    logic        [49:0] dx2;
    logic        [49:0] dy2;
    logic        [41:0] rs2;
    logic        [21:0] adx;
    logic        [21:0] ady;
    logic               hit;
    logic        [41:0] d2;
  } f_t;

  f_t         st  [1:S];
  f_t         nxt [1:S];
  f_t         sa  [0:S];
  logic [S:1] v;
  logic [S:0] vs;
  logic [S+1:1] en;

  assign vs = {v, in_valid};

  always_comb begin
    en[S+1] = out_ready;
    for (int k = S; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_comb begin
    sa[0]   = '0;
    sa[0].p = in_pair;
    for (int k = 1; k <= S; k++) begin
      sa[k] = st[k];
    end
  end

  always_comb begin
    logic [50:0] d2f;
    nxt[1]    = sa[0];
    nxt[1].dx = sa[0].p.b.x - sa[0].p.a.x;
    nxt[1].dy = sa[0].p.b.y - sa[0].p.a.y;
    nxt[1].rs = {1'b0, sa[0].p.a.r} + {1'b0, sa[0].p.b.r};

    nxt[2]     = sa[1];
    nxt[2].dx2 = sa[1].dx * sa[1].dx;
    nxt[2].dy2 = sa[1].dy * sa[1].dy;
    nxt[2].rs2 = sa[1].rs * sa[1].rs;
    nxt[2].adx = sa[1].dx[24] ? 22'(-sa[1].dx) : 22'(sa[1].dx);
    nxt[2].ady = sa[1].dy[24] ? 22'(-sa[1].dy) : 22'(sa[1].dy);

    d2f        = {1'b0, sa[2].dx2} + {1'b0, sa[2].dy2};
    nxt[3]     = sa[2];
    nxt[3].hit = (d2f != '0) && (d2f < {9'b0, sa[2].rs2});
    nxt[3].d2  = d2f[41:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= S; k++) begin
        if (en[k]) begin
          v[k] <= vs[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= S; k++) begin
      if (en[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign in_ready   = en[1];
  assign out_valid  = v[S];
  assign geom.p     = sa[S].p;
  assign geom.dx    = sa[S].dx;
  assign geom.dy    = sa[S].dy;
  assign geom.rs    = sa[S].rs;
  assign geom.adx   = sa[S].adx;
  assign geom.ady   = sa[S].ady;
  assign geom.hit   = sa[S].hit;
  assign d2         = sa[S].d2;

endmodule

// File: rtl/ccr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module ccr_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ccr_pkg::geom_t          geom,
  input  logic [ccr_pkg::D2W-1:0] d2,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ccr_pkg::root_t          root
);

  localparam int S   = ccr_pkg::SQ_STEPS;
  localparam int D2W = ccr_pkg::D2W;

  typedef struct packed {
    ccr_pkg::geom_t   g;
    logic [D2W-1:0]   rem;
    logic [D2W-1:0]   res;
  } sq_t;

  sq_t          st  [1:S];
  sq_t          nxt [1:S];
  sq_t          sa  [0:S];
  logic [S:1]   v;
  logic [S:0]   vs;
  logic [S+1:1] en;

  assign vs = {v, in_valid};

  always_comb begin
    en[S+1] = out_ready;
    for (int k = S; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_comb begin
    sa[0].g   = geom;
    sa[0].rem = d2;
    sa[0].res = '0;
    for (int k = 1; k <= S; k++) begin
      sa[k] = st[k];
    end
  end

  always_comb begin
    logic [D2W-1:0] bitv;
    logic [D2W-1:0] trial;
    for (int k = 1; k <= S; k++) begin
      bitv     = D2W'(1) << (D2W - 2 * k);
      trial    = sa[k-1].res + bitv;
      nxt[k].g = sa[k-1].g;
      if (sa[k-1].rem >= trial) begin
        nxt[k].rem = sa[k-1].rem - trial;
        nxt[k].res = (sa[k-1].res >> 1) + bitv;
      end else begin
        nxt[k].rem = sa[k-1].rem;
        nxt[k].res = sa[k-1].res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= S; k++) begin
        if (en[k]) begin
          v[k] <= vs[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= S; k++) begin
      if (en[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[S];
  assign root.g    = sa[S].g;
  assign root.dmag = sa[S].res[ccr_pkg::DISTW-1:0];

endmodule

// File: rtl/ccr_div.sv
// Pipelined restoring dividers for the normal magnitudes, one quotient bit per stage.
module ccr_div #(
  parameter int NORM_BITS = ccr_pkg::FRAC_BITS_DEF + ccr_pkg::NORM_EXTRA
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ccr_pkg::root_t       root_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ccr_pkg::root_t       root_out,
  output logic [NORM_BITS:0]   qx,
  output logic [NORM_BITS:0]   qy
);

  localparam int S = NORM_BITS + 1;

  typedef struct packed {
    ccr_pkg::root_t     r;
    logic [21:0]        rx;
    logic [21:0]        ry;
    logic [NORM_BITS:0] qx;
    logic [NORM_BITS:0] qy;
  } dv_t;

  dv_t          st  [1:S];
  dv_t          nxt [1:S];
  dv_t          sa  [0:S];
  logic [S:1]   v;
  logic [S:0]   vs;
  logic [S+1:1] en;

  assign vs = {v, in_valid};

  always_comb begin
    en[S+1] = out_ready;
    for (int k = S; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_comb begin
    sa[0].r  = root_in;
    sa[0].rx = root_in.g.adx;
    sa[0].ry = root_in.g.ady;
    sa[0].qx = '0;
    sa[0].qy = '0;
    for (int k = 1; k <= S; k++) begin
      sa[k] = st[k];
    end
  end

  always_comb begin
    logic [22:0] tx;
    logic [22:0] ty;
    logic [22:0] dd;
    logic        gx;
    logic        gy;
    for (int k = 1; k <= S; k++) begin
      dd = {2'b0, sa[k-1].r.dmag};
      // first step takes the integer bit, later steps shift in a zero
      tx = (k == 1) ? {1'b0, sa[k-1].rx} : {sa[k-1].rx, 1'b0};
      ty = (k == 1) ? {1'b0, sa[k-1].ry} : {sa[k-1].ry, 1'b0};
      gx = tx >= dd;
      gy = ty >= dd;
      nxt[k].r  = sa[k-1].r;
      nxt[k].rx = gx ? 22'(tx - dd) : tx[21:0];
      nxt[k].ry = gy ? 22'(ty - dd) : ty[21:0];
      nxt[k].qx = {sa[k-1].qx[NORM_BITS-1:0], gx};
      nxt[k].qy = {sa[k-1].qy[NORM_BITS-1:0], gy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= S; k++) begin
        if (en[k]) begin
          v[k] <= vs[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= S; k++) begin
      if (en[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[S];
  assign root_out  = sa[S].r;
  assign qx        = sa[S].qx;
  assign qy        = sa[S].qy;

endmodule

// File: rtl/ccr_resp.sv
// Response stages: separation shift, momentum exchange, saturation and result register.
module ccr_resp #(
  parameter int NORM_BITS = ccr_pkg::FRAC_BITS_DEF + ccr_pkg::NORM_EXTRA
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ccr_pkg::root_t       root,
  input  logic [NORM_BITS:0]   qx,
  input  logic [NORM_BITS:0]   qy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ccr_pkg::result_t     res
);

  localparam int S  = 8;
  localparam int NB = NORM_BITS;
  localparam logic signed [NB+23:0] HALF_S = (NB+24)'(1) << NB;
  localparam logic signed [NB+27:0] HALF_Q = (NB+28)'(1) << (NB - 1);
  localparam logic signed [NB+30:0] HALF_E = (NB+31)'(1) << (NB - 1);

  typedef struct packed {
    ccr_pkg::root_t      r;
    logic [NB:0]         qx;
    logic [NB:0]         qy;
    logic signed [NB+1:0]  nx;
    logic signed [NB+1:0]  ny;
    logic signed [21:0]    gap;
    logic signed [NB+23:0] pgx;
    logic signed [NB+23:0] pgy;
    logic signed [NB+25:0] a1x;
    logic signed [NB+25:0] a1y;
    logic signed [NB+25:0] b2x;
    logic signed [NB+25:0] b2y;
    logic signed [23:0]    sx;
    logic signed [23:0]    sy;
    logic signed [NB+26:0] c1;
    logic signed [NB+26:0] c2;
    logic signed [NB+27:0] dd;
    logic signed [23:0]    x1;
    logic signed [23:0]    y1;
    logic signed [23:0]    x2;
    logic signed [23:0]    y2;
    logic signed [28:0]    q;
    logic signed [NB+30:0] epx;
    logic signed [NB+30:0] epy;
    logic signed [30:0]    ex;
    logic signed [30:0]    ey;
    ccr_pkg::result_t      res;
  } rs_t;

  rs_t          st  [1:S];
  rs_t          nxt [1:S];
  rs_t          sa  [0:S];
  logic [S:1]   v;
  logic [S:0]   vs;
  logic [S+1:1] en;

  assign vs = {v, in_valid};

  always_comb begin
    en[S+1] = out_ready;
    for (int k = S; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_comb begin
    sa[0]    = '0;
    sa[0].r  = root;
    sa[0].qx = qx;
    sa[0].qy = qy;
    for (int k = 1; k <= S; k++) begin
      sa[k] = st[k];
    end
  end

  // rounding is half away from zero: add half, less one when negative, then shift
  always_comb begin
    logic signed [NB+23:0] tpx;
    logic signed [NB+23:0] tpy;
    logic signed [NB+27:0] tq;
    logic signed [NB+30:0] tex;
    logic signed [NB+30:0] tey;
    logic signed [39:0]    t1;
    logic signed [39:0]    t2;
    logic signed [39:0]    t3;
    logic signed [39:0]    t4;
    logic                  xchg;

    // signed normal and overlap
    nxt[1]     = sa[0];
    nxt[1].nx  = sa[0].r.g.dx[24] ? -$signed({1'b0, sa[0].qx}) : $signed({1'b0, sa[0].qx});
    nxt[1].ny  = sa[0].r.g.dy[24] ? -$signed({1'b0, sa[0].qy}) : $signed({1'b0, sa[0].qy});
    nxt[1].gap = $signed({1'b0, sa[0].r.g.rs}) - $signed({1'b0, sa[0].r.dmag});

    // products
    nxt[2]     = sa[1];
    nxt[2].pgx = sa[1].nx * sa[1].gap;
    nxt[2].pgy = sa[1].ny * sa[1].gap;
    nxt[2].a1x = sa[1].r.g.p.a.mx * sa[1].nx;
    nxt[2].a1y = sa[1].r.g.p.a.my * sa[1].ny;
    nxt[2].b2x = sa[1].r.g.p.b.mx * sa[1].nx;
    nxt[2].b2y = sa[1].r.g.p.b.my * sa[1].ny;

    // half-overlap shift, projections
    tpx       = sa[2].pgx + HALF_S - {{(NB+23){1'b0}}, sa[2].pgx[NB+23]};
    tpy       = sa[2].pgy + HALF_S - {{(NB+23){1'b0}}, sa[2].pgy[NB+23]};
    nxt[3]    = sa[2];
    nxt[3].sx = 24'(tpx >>> (NB + 1));
    nxt[3].sy = 24'(tpy >>> (NB + 1));
    nxt[3].c1 = sa[2].a1x + sa[2].a1y;
    nxt[3].c2 = sa[2].b2x + sa[2].b2y;

    // new centers, projection difference
    t1        = sa[3].r.g.p.a.x - sa[3].sx;
    t2        = sa[3].r.g.p.a.y - sa[3].sy;
    t3        = sa[3].r.g.p.b.x + sa[3].sx;
    t4        = sa[3].r.g.p.b.y + sa[3].sy;
    nxt[4]    = sa[3];
    nxt[4].x1 = ccr_pkg::sat24(t1);
    nxt[4].y1 = ccr_pkg::sat24(t2);
    nxt[4].x2 = ccr_pkg::sat24(t3);
    nxt[4].y2 = ccr_pkg::sat24(t4);
    nxt[4].dd = sa[3].c2 - sa[3].c1;

    tq       = sa[4].dd + HALF_Q - {{(NB+27){1'b0}}, sa[4].dd[NB+27]};
    nxt[5]   = sa[4];
    nxt[5].q = 29'(tq >>> NB);

    nxt[6]     = sa[5];
    nxt[6].epx = sa[5].q * sa[5].nx;
    nxt[6].epy = sa[5].q * sa[5].ny;

    tex       = sa[6].epx + HALF_E - {{(NB+30){1'b0}}, sa[6].epx[NB+30]};
    tey       = sa[6].epy + HALF_E - {{(NB+30){1'b0}}, sa[6].epy[NB+30]};
    nxt[7]    = sa[6];
    nxt[7].ex = 31'(tex >>> NB);
    nxt[7].ey = 31'(tey >>> NB);

    // select and saturate the result word
    xchg   = sa[7].r.g.hit && sa[7].r.g.p.swap;
    t1     = sa[7].r.g.p.a.mx + sa[7].ex;
    t2     = sa[7].r.g.p.a.my + sa[7].ey;
    t3     = sa[7].r.g.p.b.mx - sa[7].ex;
    t4     = sa[7].r.g.p.b.my - sa[7].ey;
    nxt[8] = sa[7];
    nxt[8].res.collided = sa[7].r.g.hit;
    nxt[8].res.x1  = sa[7].r.g.hit ? sa[7].x1 : sa[7].r.g.p.a.x;
    nxt[8].res.y1  = sa[7].r.g.hit ? sa[7].y1 : sa[7].r.g.p.a.y;
    nxt[8].res.x2  = sa[7].r.g.hit ? sa[7].x2 : sa[7].r.g.p.b.x;
    nxt[8].res.y2  = sa[7].r.g.hit ? sa[7].y2 : sa[7].r.g.p.b.y;
    nxt[8].res.mx1 = xchg ? ccr_pkg::sat24(t1) : sa[7].r.g.p.a.mx;
    nxt[8].res.my1 = xchg ? ccr_pkg::sat24(t2) : sa[7].r.g.p.a.my;
    nxt[8].res.mx2 = xchg ? ccr_pkg::sat24(t3) : sa[7].r.g.p.b.mx;
    nxt[8].res.my2 = xchg ? ccr_pkg::sat24(t4) : sa[7].r.g.p.b.my;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= S; k++) begin
        if (en[k]) begin
          v[k] <= vs[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= S; k++) begin
      if (en[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[S];
  assign res       = sa[S].res;

endmodule

// File: rtl/circle_collision_response.sv
// Top level of the two-circle equal-mass collision response pipeline.
//
// Usage:
//   Slave stream (s_*) takes one circle pair per word; master stream (m_*) returns
//   one result word per pair, in order. A word moves when tvalid and tready are high.
//   Pipeline: 3 front stages (deltas, squares, overlap test), 21 square-root stages
//   (one root bit each), FRAC_BITS+9 divider stages (one normal bit each, x and y
//   in parallel), 8 response stages ending in the output register.
//   Depth: FRAC_BITS + 41 register stages from the input to the result word.
//   Throughput: one word per cycle, sustained while m_tready is high.
//   Every stage carries its own valid bit and loads whenever it is empty or its
//   successor moves, so bubbles close up and a waiting result does not block input
//   until every stage is full. When m_tready is low the result word holds and
//   s_tready drops only once the pipeline has no empty stage left.
//   Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
//   Pairs with coincident centers or no overlap pass through unchanged, collided = 0.
module circle_collision_response #(
  parameter int FRAC_BITS = ccr_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_x, first_y, first_radius, first_mom_x, first_mom_y,
  // second_x, second_y, second_radius, second_mom_x, second_mom_y
  input  logic [231:0] s_tdata,
  // both_have_momentum
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_first_x, new_first_y, new_second_x, new_second_y,
  // new_first_mom_x, new_first_mom_y, new_second_mom_x, new_second_mom_y
  output logic [191:0] m_tdata,
  // collided
  output logic         m_tuser
);

  localparam int NORM_BITS = FRAC_BITS + ccr_pkg::NORM_EXTRA;

  ccr_pkg::pair_t   in_pair;
  ccr_pkg::geom_t   fr_geom;
  logic [ccr_pkg::D2W-1:0] fr_d2;
  logic             fr_valid;
  logic             fr_ready;
  ccr_pkg::root_t   sq_root;
  logic             sq_valid;
  logic             sq_ready;
  ccr_pkg::root_t   dv_root;
  logic [NORM_BITS:0] dv_qx;
  logic [NORM_BITS:0] dv_qy;
  logic             dv_valid;
  logic             dv_ready;
  ccr_pkg::result_t res;

  // unpack the input word
  assign in_pair.a.x  = s_tdata[23:0];
  assign in_pair.a.y  = s_tdata[47:24];
  assign in_pair.a.r  = s_tdata[67:48];
  assign in_pair.a.mx = s_tdata[91:68];
  assign in_pair.a.my = s_tdata[115:92];
  assign in_pair.b.x  = s_tdata[139:116];
  assign in_pair.b.y  = s_tdata[163:140];
  assign in_pair.b.r  = s_tdata[183:164];
  assign in_pair.b.mx = s_tdata[207:184];
  assign in_pair.b.my = s_tdata[231:208];
  assign in_pair.swap = s_tuser;

  // deltas, squared distance, exact overlap compare
  ccr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pair   (in_pair),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .geom      (fr_geom),
    .d2        (fr_d2)
  );

  // floor(sqrt(d2)); only meaningful on a hit, where d2 fits the root width
  ccr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .geom      (fr_geom),
    .d2        (fr_d2),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .root      (sq_root)
  );

  // |dx|, |dy| scaled by 2^NORM_BITS over the distance
  ccr_div #(
    .NORM_BITS (NORM_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .root_in   (sq_root),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .root_out  (dv_root),
    .qx        (dv_qx),
    .qy        (dv_qy)
  );

  // push apart, swap normal momentum, saturate, hold the result word
  ccr_resp #(
    .NORM_BITS (NORM_BITS)
  ) u_resp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .root      (dv_root),
    .qx        (dv_qx),
    .qy        (dv_qy),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  // pack the result word
  assign m_tdata = {res.my2, res.mx2, res.my1, res.mx1, res.y2, res.x2, res.y1, res.x1};
  assign m_tuser = res.collided;

`ifndef ASSERT_OFF
  localparam logic [NORM_BITS:0] ONE_NORM = (NORM_BITS+1)'(1) << NORM_BITS;

  // on a hit the root is nonzero and below the radius sum
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    sq_valid && sq_root.g.hit |-> (sq_root.dmag != '0) && (sq_root.dmag < sq_root.g.rs))
    else $error("root out of range on a hit");

  // on a hit, normal components never exceed one
  a_norm_unit: assert property (@(posedge clk) disable iff (rst)
    dv_valid && dv_root.g.hit |-> (dv_qx <= ONE_NORM) && (dv_qy <= ONE_NORM))
    else $error("normal component above one");

  // input stalls only when the pipeline is backed up to a held result
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

// File: tb/tb.sv
// Testbench for the circle collision response pipeline: directed rows, then random pairs.
`timescale 1ns / 1ps

module tb;

  localparam int NORM_SH   = ccr_pkg::FRAC_BITS_DEF + ccr_pkg::NORM_EXTRA;
  localparam int LATENCY   = ccr_pkg::FRAC_BITS_DEF + 41;
  localparam int STALL_MAX = 3000;
  localparam int N_RANDOM  = 100;

  // one directed row: pair plus whether the result is simply the input passed through
  typedef struct {
    ccr_pkg::pair_t p;
    bit             passthru;
  } dir_row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [231:0] s_tdata = '0;  // first x,y,r,mx,my then second x,y,r,mx,my
  logic         s_tuser = 0;   // both_have_momentum
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [191:0] m_tdata;       // x1,y1,x2,y2,mx1,my1,mx2,my2
  logic         m_tuser;       // collided

  ccr_pkg::result_t resp_q[$];
  dir_row_t  dir_rows[$];
  int        n_err = 0;
  int        src_idle = 0;
  int        snk_stall = 0;
  int        quiet = 0;

  circle_collision_response dut (.*);

  always #10 clk = ~clk;

  always @(negedge clk) m_tready <= ($urandom_range(99) >= snk_stall);

  // ---------------- response predictor ----------------
  function automatic longint rnd_sh(longint v, int sh);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic ccr_pkg::result_t collide(ccr_pkg::pair_t p);
    ccr_pkg::result_t r;
    longint x1, y1, x2, y2, mx1, my1, mx2, my2, dx, dy, rs, dmag, nx, ny, gap, sx, sy;
    longint c1, c2, q, ex, ey;
    longint unsigned d2;
    bit hit;
    x1 = p.a.x; y1 = p.a.y; mx1 = p.a.mx; my1 = p.a.my;
    x2 = p.b.x; y2 = p.b.y; mx2 = p.b.mx; my2 = p.b.my;
    dx = x2 - x1;
    dy = y2 - y1;
    d2 = dx * dx + dy * dy;
    rs = longint'(p.a.r) + longint'(p.b.r);
    hit = (d2 != 0) && (d2 < rs * rs);
    if (hit) begin
      dmag = root_floor(d2);
      nx = (dx <<< NORM_SH) / dmag;  // truncates toward zero
      ny = (dy <<< NORM_SH) / dmag;
      gap = rs - dmag;
      sx = rnd_sh(nx * gap, NORM_SH + 1);  // half the overlap each way
      sy = rnd_sh(ny * gap, NORM_SH + 1);
      x1 -= sx; y1 -= sy;
      x2 += sx; y2 += sy;
      if (p.swap) begin
        c1 = mx1 * nx + my1 * ny;
        c2 = mx2 * nx + my2 * ny;
        q = rnd_sh(c2 - c1, NORM_SH);
        ex = rnd_sh(q * nx, NORM_SH);
        ey = rnd_sh(q * ny, NORM_SH);
        mx1 += ex; my1 += ey;
        mx2 -= ex; my2 -= ey;
      end
    end
    r.collided = hit;
    r.x1 = clamp24(x1);   r.y1 = clamp24(y1);
    r.x2 = clamp24(x2);   r.y2 = clamp24(y2);
    r.mx1 = clamp24(mx1); r.my1 = clamp24(my1);
    r.mx2 = clamp24(mx2); r.my2 = clamp24(my2);
    return r;
  endfunction

  function automatic ccr_pkg::result_t unchanged(ccr_pkg::pair_t p);
    ccr_pkg::result_t r;
    r.collided = 0;
    r.x1 = p.a.x;   r.y1 = p.a.y;   r.x2 = p.b.x;   r.y2 = p.b.y;
    r.mx1 = p.a.mx; r.my1 = p.a.my; r.mx2 = p.b.mx; r.my2 = p.b.my;
    return r;
  endfunction

  function automatic ccr_pkg::pair_t mk(longint x1, longint y1, longint r1, longint mx1,
                                        longint my1, longint x2, longint y2, longint r2,
                                        longint mx2, longint my2, bit sw);
    ccr_pkg::pair_t p;
    p.a.x = 24'(x1); p.a.y = 24'(y1); p.a.r = 20'(r1); p.a.mx = 24'(mx1); p.a.my = 24'(my1);
    p.b.x = 24'(x2); p.b.y = 24'(y2); p.b.r = 20'(r2); p.b.mx = 24'(mx2); p.b.my = 24'(my2);
    p.swap = sw;
    return p;
  endfunction

  // ---------------- checking ----------------
  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    n_err++;
  endtask

  always @(posedge clk) begin
    ccr_pkg::result_t w;
    logic signed [23:0] g[8];
    logic signed [23:0] e[8];
    if (!rst && m_tvalid && m_tready) begin
      if (resp_q.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        w = resp_q.pop_front();
        for (int i = 0; i < 8; i++) g[i] = m_tdata[24*i +: 24];
        e = '{w.x1, w.y1, w.x2, w.y2, w.mx1, w.my1, w.mx2, w.my2};
        if (m_tuser !== w.collided) report("collided", m_tuser, w.collided);
        for (int i = 0; i < 8; i++)
          if (g[i] !== e[i]) report($sformatf("result field %0d", i), g[i], e[i]);
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic send(ccr_pkg::pair_t p, bit passthru);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser  = p.swap;
    s_tdata  = {p.b.my, p.b.mx, p.b.r, p.b.y, p.b.x, p.a.my, p.a.mx, p.a.r, p.a.y, p.a.x};
    do @(posedge clk); while (!s_tready);
    resp_q.push_back(passthru ? unchanged(p) : collide(p));
    @(negedge clk);
    s_tvalid = 0;
  endtask

  function automatic ccr_pkg::pair_t rand_pair();
    ccr_pkg::pair_t p;
    logic [255:0] raw;
    longint r1, r2, rs, x1, y1;
    int kind;
    kind = $urandom_range(99);
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p = raw[$bits(ccr_pkg::pair_t)-1:0];
    p.swap = 1'($urandom_range(1));
    if (kind < 75) begin
      // nearby pair, often overlapping, mostly moderate sizes, a few huge radii
      r1 = (kind < 10) ? $urandom_range(1048575) : $urandom_range(20000);
      r2 = (kind < 10) ? $urandom_range(1048575) : $urandom_range(20000);
      rs = r1 + r2 + 1;
      x1 = $signed($urandom_range(8388607)) - 4194304;
      y1 = $signed($urandom_range(8388607)) - 4194304;
      p.a.r = 20'(r1); p.b.r = 20'(r2);
      p.a.x = 24'(x1); p.a.y = 24'(y1);
      p.b.x = 24'(x1 + longint'($urandom_range(2 * rs)) - rs);
      p.b.y = 24'(y1 + longint'($urandom_range(2 * rs)) - rs);
      if (kind < 20) begin  // small x momentum for the first circle, small y momentum for the second
        p.a.mx = 24'($signed($urandom_range(200000)) - 100000);
        p.b.my = 24'($signed($urandom_range(200000)) - 100000);
      end
    end
    return p;
  endfunction

  initial begin
    // far apart, zero everything else
    dir_rows.push_back('{mk(0, 0, 0, 0, 0, 25600, 0, 0, 0, 0, 1), 1});
    // same point at the extremes: coincident, stays put
    dir_rows.push_back('{mk(8388607, 8388607, 1048575, 8388607, 8388607,
                            8388607, 8388607, 1048575, -8388608, -8388608, 1), 1});
    dir_rows.push_back('{mk(-8388608, -8388608, 1048575, -8388608, 8388607,
                            -8388608, -8388608, 1048575, 8388607, -8388608, 0), 1});
    // widest separation, largest radii: no overlap
    dir_rows.push_back('{mk(-8388608, -8388608, 1048575, 8388607, -8388608,
                            8388607, 8388607, 1048575, -8388608, 8388607, 1), 1});
    // touching exactly: distance equals radius sum
    dir_rows.push_back('{mk(0, 0, 256, 100, 0, 512, 0, 256, -100, 0, 1), 1});
    dir_rows.push_back('{mk(0, 0, 300, 0, 0, 0, -600, 300, 0, 0, 1), 1});
    // head-on overlap along x, with and without exchange
    dir_rows.push_back('{mk(0, 0, 512, 256, 0, 512, 0, 512, -256, 0, 1), 0});
    dir_rows.push_back('{mk(0, 0, 512, 256, 0, 512, 0, 512, -256, 0, 0), 0});
    // diagonal overlap, mixed momenta
    dir_rows.push_back('{mk(-1000, 2000, 3000, 777, -333, 1500, -500, 2500, -12, 999, 1), 0});
    // pushed past the negative edge: saturates
    dir_rows.push_back('{mk(-8388608, -8388608, 1048575, -8388608, -8388608,
                            -8388352, -8388352, 1048575, 8388607, 8388607, 1), 0});
    // pushed past the positive edge, extreme momenta without exchange
    dir_rows.push_back('{mk(8388000, 8388607, 1048575, 8388607, -8388608,
                            8388607, 8388600, 1048575, -8388608, 8388607, 0), 0});
    // tiny separation, one bit apart
    dir_rows.push_back('{mk(5, 5, 1, 1, 1, 6, 5, 1, -1, -1, 1), 0});
    dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 1, 2, 0, 0, 1), 0});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (dir_rows[i]) send(dir_rows[i].p, dir_rows[i].passthru);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 75; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 75; end
        default: begin src_idle = 27; snk_stall = 27; end
      endcase
      for (int k = 0; k < N_RANDOM; k++) send(rand_pair(), 0);
      // hold off the sender until the pipe has drained once
      if (ph == 1) while (resp_q.size() != 0) @(negedge clk);
    end

    while (resp_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
